/* hw/rtl/multiword_schoolbook_multiplier_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multiword schoolbook multiplier
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTIWORD_SCHOOLBOOK_MULTIPLIER_ASSERT_SVH
`define MULTIWORD_SCHOOLBOOK_MULTIPLIER_ASSERT_SVH

`ifndef SYNTHESIS
`define MSM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("msm assertion failed");
`define MSM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("msm assertion failed");
`else
`define MSM_ASSERT(name, prop)
`define MSM_ASSERT_ALWAYS(name, prop)
`endif

`endif

/* hw/rtl/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam int unsigned MAX_WORDS_DEF = 16;

  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned PROD_W    = 2 * LIMB_W;
  localparam int unsigned CARRY_W   = LIMB_W + 1;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned PIDX_W    = 6;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned OPC_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DATA_W    = 40;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_MULTIPLY = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_LENGTH = 1'd0,
    REG_B_LENGTH = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [IDX_W-1:0]  wr_idx;
    logic              rd_a;
    logic [IDX_W-1:0]  a_idx;
    logic              carry_clr;
    logic              mac_issue;
    logic              first_row;
    logic [IDX_W-1:0]  b_idx;
    logic [PIDX_W-1:0] p_idx;
    logic              carry_wr;
    logic              emit_rd;
    logic              emit_load;
    logic              emit_last;
    logic [PIDX_W-1:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/msm_ram.sv */
// ----------------------------------------------------------------------------
// msm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/msm_datapath.sv */
// ----------------------------------------------------------------------------
// msm_datapath
// Operand and product RAMs, limb multiply-accumulate pipe and output register.
// ----------------------------------------------------------------------------
`include "multiword_schoolbook_multiplier_assert.svh"

module msm_datapath #(
  parameter int unsigned MAX_WORDS = msm_pkg::MAX_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msm_pkg::dp_cmd_t            cmd_i,
  input  logic [msm_pkg::LIMB_W-1:0]  limb_value_i,
  output msm_pkg::dp_sts_t            sts_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [msm_pkg::LIMB_W-1:0]  product_limb_o,
  output logic [msm_pkg::PIDX_W-1:0]  product_index_o,
  output logic                        last_limb_o
);

  localparam int unsigned OP_LIMBS   = 2 * MAX_WORDS;
  localparam int unsigned PROD_LIMBS = 4 * MAX_WORDS;
  localparam int unsigned AW         = $clog2(OP_LIMBS);
  localparam int unsigned PW         = $clog2(PROD_LIMBS);
  localparam int unsigned LW         = msm_pkg::LIMB_W;

  logic [LW-1:0] a_rdata, b_rdata, p_rdata;

  logic                         a_pend_q;
  logic [LW-1:0]                a_q;
  logic                         s1_valid_q, s1_zero_q;
  logic [PW-1:0]                s1_addr_q;
  logic                         s2_valid_q;
  logic [msm_pkg::PROD_W-1:0]   mul_q, mul_d;
  logic [LW-1:0]                p_q, p_d;
  logic [PW-1:0]                s2_addr_q;
  logic [msm_pkg::CARRY_W-1:0]  carry_q, carry_d;
  logic [LW+1:0]                low;

  logic                         out_valid_q;
  logic [LW-1:0]                out_limb_q;
  logic [msm_pkg::PIDX_W-1:0]   out_idx_q;
  logic                         out_last_q;

  logic          p_we;
  logic [PW-1:0] p_waddr;
  logic [LW-1:0] p_wdata;

  msm_ram #(.WIDTH(LW), .DEPTH(OP_LIMBS)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (cmd_i.wr_idx[AW-1:0]),
    .wdata_i (limb_value_i),
    .re_i    (cmd_i.rd_a),
    .raddr_i (cmd_i.a_idx[AW-1:0]),
    .rdata_o (a_rdata)
  );

  msm_ram #(.WIDTH(LW), .DEPTH(OP_LIMBS)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (cmd_i.wr_idx[AW-1:0]),
    .wdata_i (limb_value_i),
    .re_i    (cmd_i.mac_issue),
    .raddr_i (cmd_i.b_idx[AW-1:0]),
    .rdata_o (b_rdata)
  );

  msm_ram #(.WIDTH(LW), .DEPTH(PROD_LIMBS)) u_p_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (cmd_i.mac_issue | cmd_i.emit_rd),
    .raddr_i (cmd_i.p_idx[PW-1:0]),
    .rdata_o (p_rdata)
  );

  // row 0 sees an empty product
  assign mul_d = msm_pkg::PROD_W'(a_q) * msm_pkg::PROD_W'(b_rdata);
  assign p_d   = s1_zero_q ? '0 : p_rdata;

  assign low     = {2'b00, mul_q[LW-1:0]} + {2'b00, p_q} + {1'b0, carry_q};
  assign carry_d = {1'b0, mul_q[msm_pkg::PROD_W-1:LW]} + {{(LW-1){1'b0}}, low[LW+1:LW]};

  assign p_we    = s2_valid_q | cmd_i.carry_wr;
  assign p_waddr = s2_valid_q ? s2_addr_q : cmd_i.p_idx[PW-1:0];
  assign p_wdata = s2_valid_q ? low[LW-1:0] : carry_q[LW-1:0];

  assign sts_o.out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pend_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_pend_q   <= cmd_i.rd_a;
      s1_valid_q <= cmd_i.mac_issue;
      s2_valid_q <= s1_valid_q;
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_pend_q) begin
      a_q <= a_rdata;
    end
    s1_zero_q <= cmd_i.first_row;
    s1_addr_q <= cmd_i.p_idx[PW-1:0];
    mul_q     <= mul_d;
    p_q       <= p_d;
    s2_addr_q <= s1_addr_q;
    if (cmd_i.carry_clr) begin
      carry_q <= '0;
    end else if (s2_valid_q) begin
      carry_q <= carry_d;
    end
    if (cmd_i.emit_load) begin
      out_limb_q <= p_rdata;
      out_idx_q  <= cmd_i.out_idx;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign m_valid_o       = out_valid_q;
  assign product_limb_o  = out_limb_q;
  assign product_index_o = out_idx_q;
  assign last_limb_o     = out_last_q;

  `MSM_ASSERT(a_no_write_clash, !(s2_valid_q && cmd_i.carry_wr))
  `MSM_ASSERT(a_load_when_free, cmd_i.emit_load |-> (!out_valid_q || m_ready_i))

endmodule

/* hw/rtl/msm_ctrl.sv */
// ----------------------------------------------------------------------------
// msm_ctrl
// Length registers and sequencer: loads, row/column walk, carry and emission.
// ----------------------------------------------------------------------------
`include "multiword_schoolbook_multiplier_assert.svh"

module msm_ctrl #(
  parameter int unsigned MAX_WORDS = msm_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [msm_pkg::OPC_W-1:0]     opcode_i,
  input  logic [msm_pkg::IDX_W-1:0]     limb_index_i,
  input  logic                          cfg_we_i,
  input  logic [msm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [msm_pkg::LEN_W-1:0]     cfg_data_i,
  input  msm_pkg::dp_sts_t              sts_i,
  output msm_pkg::dp_cmd_t              cmd_o
);

  localparam int unsigned IW = msm_pkg::IDX_W;
  localparam int unsigned PW = msm_pkg::PIDX_W;
  localparam logic [PW-1:0]              OP_LIMBS = PW'(2 * MAX_WORDS);
  localparam logic [msm_pkg::LEN_W-1:0]  MAX_LEN  = msm_pkg::LEN_W'(MAX_WORDS);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_AREAD   = 8'b0000_0010,
    ST_ISSUE   = 8'b0000_0100,
    ST_DRAIN1  = 8'b0000_1000,
    ST_DRAIN2  = 8'b0001_0000,
    ST_CARRY   = 8'b0010_0000,
    ST_EMIT_RD = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [msm_pkg::LEN_W-1:0] a_len_q, b_len_q;
  logic [msm_pkg::LEN_W-1:0] a_words, b_words;
  logic [PW-1:0]             a_dbl, b_dbl;
  logic [IW-1:0]             a_last_q, a_last_d, b_last_q, b_last_d;
  logic [PW-1:0]             tot_last_q, tot_last_d;
  logic [IW-1:0]             i_q, i_d, j_q, j_d;
  logic [PW-1:0]             k_q, k_d;
  logic                      in_range;

  always_comb begin
    a_words = (a_len_q == '0) ? 5'd1 : ((a_len_q > MAX_LEN) ? MAX_LEN : a_len_q);
    b_words = (b_len_q == '0) ? 5'd1 : ((b_len_q > MAX_LEN) ? MAX_LEN : b_len_q);
    a_dbl   = {a_words, 1'b0} - 6'd1;
    b_dbl   = {b_words, 1'b0} - 6'd1;
  end

  assign in_range  = {1'b0, limb_index_i} < OP_LIMBS;
  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    a_last_d   = a_last_q;
    b_last_d   = b_last_q;
    tot_last_d = tot_last_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cmd_o        = '0;
    cmd_o.wr_idx = limb_index_i;
    cmd_o.a_idx  = i_q;
    cmd_o.b_idx  = j_q;

    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          case (msm_pkg::opcode_e'(opcode_i))
            msm_pkg::OP_LOAD_A: begin
              cmd_o.wr_a = in_range;
            end
            msm_pkg::OP_LOAD_B: begin
              cmd_o.wr_b = in_range;
            end
            msm_pkg::OP_MULTIPLY: begin
              a_last_d   = a_dbl[IW-1:0];
              b_last_d   = b_dbl[IW-1:0];
              tot_last_d = {1'b0, a_dbl[IW-1:0]} + {1'b0, b_dbl[IW-1:0]} + 6'd1;
              i_d        = '0;
              state_d    = ST_AREAD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_AREAD: begin
        cmd_o.rd_a      = 1'b1;
        cmd_o.carry_clr = 1'b1;
        j_d             = '0;
        state_d         = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.first_row = (i_q == '0);
        cmd_o.p_idx     = {1'b0, i_q} + {1'b0, j_q};
        if (j_q == b_last_q) begin
          state_d = ST_DRAIN1;
        end else begin
          j_d = j_q + 5'd1;
        end
      end
      ST_DRAIN1: begin
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = ST_CARRY;
      end
      ST_CARRY: begin
        cmd_o.carry_wr = 1'b1;
        cmd_o.p_idx    = {1'b0, i_q} + {1'b0, b_last_q} + 6'd1;
        if (i_q == a_last_q) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          i_d     = i_q + 5'd1;
          state_d = ST_AREAD;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        cmd_o.p_idx   = k_q;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.out_idx   = k_q;
          cmd_o.emit_last = (k_q == tot_last_q);
          if (k_q == tot_last_q) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.emit_rd = 1'b1;
            cmd_o.p_idx   = k_q + 6'd1;
            k_d           = k_q + 6'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      a_len_q    <= 5'd1;
      b_len_q    <= 5'd1;
      a_last_q   <= '0;
      b_last_q   <= '0;
      tot_last_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      a_last_q   <= a_last_d;
      b_last_q   <= b_last_d;
      tot_last_q <= tot_last_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      if (cfg_we_i) begin
        case (msm_pkg::cfg_reg_e'(cfg_idx_i))
          msm_pkg::REG_A_LENGTH: a_len_q <= cfg_data_i;
          msm_pkg::REG_B_LENGTH: b_len_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  `MSM_ASSERT(a_col_in_row, (state_q == ST_ISSUE) |-> (j_q <= b_last_q))
  `MSM_ASSERT(a_row_in_range, (state_q == ST_CARRY) |-> (i_q <= a_last_q))
  `MSM_ASSERT(a_emit_in_range, cmd_o.emit_load |-> (k_q <= tot_last_q))

endmodule

/* hw/rtl/multiword_schoolbook_multiplier.sv */
// ----------------------------------------------------------------------------
// multiword_schoolbook_multiplier
// Unsigned multi-limb schoolbook multiplier on 32-bit limbs.
// ----------------------------------------------------------------------------
// Load words (kind 0 for A, 1 for B) each write one limb; a limb index at or
// beyond 2*MAX_WORDS is dropped. A multiply word with lengths A and B (64-bit
// words, clamped to 1..MAX_WORDS) runs 2A rows (A read, 2B multiply-accumulate
// issues, drain, carry write), then sends 2A+2B product limbs at one per cycle
// while the output is ready, least significant first, tlast on the top limb.
// The rate is set by the single 32x32 multiply-accumulate stage, which retires
// one limb product per cycle, and by the single product RAM write port. Input
// is taken only between multiplies; the last product limb may still wait on
// the output while the next word is taken.
// ----------------------------------------------------------------------------
module multiword_schoolbook_multiplier #(
  parameter int unsigned MAX_WORDS = msm_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [4:0] limb_index, [36:5] limb_value, [39:37] zero
  input  logic [msm_pkg::DATA_W-1:0]    s_axis_tdata_i,
  // [1:0] opcode
  input  logic [msm_pkg::OPC_W-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] product_limb, [37:32] product_index, [39:38] zero
  output logic [msm_pkg::DATA_W-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_we_i,
  input  logic [msm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [msm_pkg::LEN_W-1:0]     cfg_data_i
);

  msm_pkg::dp_cmd_t cmd;
  msm_pkg::dp_sts_t sts;

  logic [msm_pkg::LIMB_W-1:0] product_limb;
  logic [msm_pkg::PIDX_W-1:0] product_index;

  msm_ctrl #(.MAX_WORDS(MAX_WORDS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .opcode_i     (s_axis_tuser_i),
    .limb_index_i (s_axis_tdata_i[4:0]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  msm_datapath #(.MAX_WORDS(MAX_WORDS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .limb_value_i    (s_axis_tdata_i[36:5]),
    .sts_o           (sts),
    .m_valid_o       (m_axis_tvalid_o),
    .m_ready_i       (m_axis_tready_i),
    .product_limb_o  (product_limb),
    .product_index_o (product_index),
    .last_limb_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, product_index, product_limb};

endmodule

/* verif/tb_multiword_schoolbook_multiplier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multiword_schoolbook_multiplier
// Self-checking bench for the multi-limb schoolbook multiplier.
// Loads operand limbs and issues multiplies over the input stream. A local
// limb-by-limb multiply predicts every product word, and each word on the
// output stream is compared field by field against the oldest prediction.
// Directed corners come first, then both lengths are swept over their
// extremes (clamped values included). A long output stall is forced so that
// the input backs up. The rest is random traffic with random idling on both
// streams.
// ----------------------------------------------------------------------------
module tb_multiword_schoolbook_multiplier;

  localparam int unsigned MAX_WORDS   = msm_pkg::MAX_WORDS_DEF;
  localparam int unsigned ITEM_TARGET = 310;
  localparam int unsigned STALL_LIMIT = 12000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned DRAIN       = 16;
  localparam logic [msm_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] limb;
    logic [5:0]  index;
    logic        is_last;
  } product_word_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [msm_pkg::DATA_W-1:0]    s_axis_tdata_i;
  logic [msm_pkg::OPC_W-1:0]     s_axis_tuser_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [msm_pkg::DATA_W-1:0]    m_axis_tdata_o;
  logic                          m_axis_tlast_o;
  logic                          cfg_we_i;
  logic [msm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [msm_pkg::LEN_W-1:0]     cfg_data_i;

  // Predictor state
  logic [msm_pkg::LEN_W-1:0] a_len_reg;
  logic [msm_pkg::LEN_W-1:0] b_len_reg;
  logic [31:0]      a_limbs [0:31];
  logic [31:0]      b_limbs [0:31];
  bit   [31:0]      a_written;
  bit   [31:0]      b_written;
  product_word_t    pending_limbs [$];

  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          src_calm    = 1'b0;
  bit          long_hold_req = 1'b0;

  multiword_schoolbook_multiplier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len(input logic [msm_pkg::LEN_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_WORDS) return MAX_WORDS;
    return 32'(raw);
  endfunction

  function automatic logic [31:0] rand_limb();
    int unsigned k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << k;
      3: return ~(32'h1 << k);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [msm_pkg::LEN_W-1:0] rand_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return msm_pkg::LEN_W'($urandom_range(1, 3));
    if (r < 84) return msm_pkg::LEN_W'($urandom_range(4, 16));
    if (r < 92) return 0;
    return msm_pkg::LEN_W'($urandom_range(17, 31));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
    if (src_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Schoolbook product over the current lengths; queues every product word.
  function automatic void compute_product();
    logic [31:0]   acc [0:63];
    logic [63:0]   prod;
    logic [63:0]   low;
    logic [63:0]   carry;
    int unsigned   alimbs;
    int unsigned   blimbs;
    int unsigned   total;
    product_word_t w;
    alimbs = 2 * eff_len(a_len_reg);
    blimbs = 2 * eff_len(b_len_reg);
    total  = alimbs + blimbs;
    for (int k = 0; k < 64; k++) acc[k] = 32'h0;
    for (int i = 0; i < alimbs; i++) begin
      carry = 64'h0;
      for (int j = 0; j < blimbs; j++) begin
        prod  = {32'h0, a_limbs[i]} * {32'h0, b_limbs[j]};
        low   = {32'h0, prod[31:0]} + {32'h0, acc[i+j]} + carry;
        acc[i+j] = low[31:0];
        carry = {32'h0, prod[63:32]} + {32'h0, low[63:32]};
      end
      acc[i+blimbs] = carry[31:0];
    end
    for (int k = 0; k < total; k++) begin
      w.limb    = acc[k];
      w.index   = 6'(k);
      w.is_last = (k + 1 == total);
      pending_limbs.push_back(w);
    end
  endfunction

  function automatic void track_word(input logic [msm_pkg::OPC_W-1:0] op,
                                     input logic [4:0] idx, input logic [31:0] val);
    case (op)
      msm_pkg::OP_LOAD_A: begin
        a_limbs[idx]   = val;
        a_written[idx] = 1'b1;
      end
      msm_pkg::OP_LOAD_B: begin
        b_limbs[idx]   = val;
        b_written[idx] = 1'b1;
      end
      msm_pkg::OP_MULTIPLY: compute_product();
      default: ;
    endcase
  endfunction

  // Called on a clock edge; returns on the edge the word is taken.
  task automatic send_word(input logic [msm_pkg::OPC_W-1:0] op, input logic [4:0] idx,
                           input logic [31:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {3'b000, val, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_word(op, idx, val);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    while (pending_limbs.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [msm_pkg::LEN_W-1:0] a_raw,
                               input logic [msm_pkg::LEN_W-1:0] b_raw);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= msm_pkg::REG_A_LENGTH;
    cfg_data_i <= a_raw;
    @(posedge clk_i);
    cfg_idx_i  <= msm_pkg::REG_B_LENGTH;
    cfg_data_i <= b_raw;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    a_len_reg = a_raw;
    b_len_reg = b_raw;
  endtask

  // Never read a limb that was not loaded.
  task automatic fill_operands();
    for (int i = 0; i < 2 * eff_len(a_len_reg); i++)
      if (!a_written[i]) send_word(msm_pkg::OP_LOAD_A, 5'(i), rand_limb());
    for (int i = 0; i < 2 * eff_len(b_len_reg); i++)
      if (!b_written[i]) send_word(msm_pkg::OP_LOAD_B, 5'(i), rand_limb());
  endtask

  task automatic test_directed_corners();
    // all-ones operands: worst carry chain
    send_word(msm_pkg::OP_LOAD_A, 0, 32'hFFFF_FFFF);
    send_word(msm_pkg::OP_LOAD_A, 1, 32'hFFFF_FFFF);
    send_word(msm_pkg::OP_LOAD_B, 0, 32'hFFFF_FFFF);
    send_word(msm_pkg::OP_LOAD_B, 1, 32'hFFFF_FFFF);
    send_word(msm_pkg::OP_MULTIPLY, 5'h00, 32'h0000_0000);
    // zero top limb still takes part
    send_word(msm_pkg::OP_LOAD_A, 1, 32'h0000_0000);
    send_word(msm_pkg::OP_MULTIPLY, 5'h1F, 32'hFFFF_FFFF);
    // zero operand
    send_word(msm_pkg::OP_LOAD_A, 0, 32'h0000_0000);
    send_word(msm_pkg::OP_MULTIPLY, 5'h00, 32'h0000_0000);
    // unused opcode must not touch the stores
    send_word(OP_UNUSED, 5'h00, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 5'h1F, 32'h5555_5555);
    send_word(msm_pkg::OP_MULTIPLY, 5'h00, 32'h0000_0000);
    // top index of both stores
    send_word(msm_pkg::OP_LOAD_A, 31, 32'hAAAA_AAAA);
    send_word(msm_pkg::OP_LOAD_B, 31, 32'h5555_5555);
    send_word(msm_pkg::OP_LOAD_A, 0, 32'h8000_0001);
    send_word(msm_pkg::OP_LOAD_B, 1, 32'h0000_0001);
    send_word(msm_pkg::OP_MULTIPLY, 5'h15, 32'hA5A5_A5A5);
  endtask

  task automatic test_length_extremes();
    logic [msm_pkg::LEN_W-1:0] a_set [5] = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17};
    logic [msm_pkg::LEN_W-1:0] b_set [5] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd2};
    for (int n = 0; n < 5; n++) begin
      quiesce();
      write_lengths(a_set[n], b_set[n]);
      fill_operands();
      send_word(msm_pkg::OP_MULTIPLY, 5'($urandom()), $urandom());
    end
  endtask

  task automatic test_output_backpressure();
    quiesce();
    write_lengths(5'd1, 5'd1);
    long_hold_req <= 1'b1;
    send_word(msm_pkg::OP_MULTIPLY, 5'h00, 32'h0000_0000);
    send_word(msm_pkg::OP_LOAD_A, 0, rand_limb());
    send_word(msm_pkg::OP_LOAD_B, 1, rand_limb());
    send_word(msm_pkg::OP_MULTIPLY, 5'h00, 32'h0000_0000);
    send_word(msm_pkg::OP_LOAD_A, 1, rand_limb());
    send_word(msm_pkg::OP_MULTIPLY, 5'h00, 32'h0000_0000);
    send_word(msm_pkg::OP_LOAD_B, 0, rand_limb());
  endtask

  task automatic test_random_traffic();
    int unsigned rounds;
    int unsigned loads;
    int unsigned r;
    int unsigned alimbs;
    int unsigned blimbs;
    while (words_sent < ITEM_TARGET) begin
      quiesce();
      write_lengths(rand_length(), rand_length());
      alimbs = 2 * eff_len(a_len_reg);
      blimbs = 2 * eff_len(b_len_reg);
      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
        loads = $urandom_range(0, 6);
        repeat (loads) begin
          r = $urandom_range(0, 99);
          if (r < 42)
            send_word(msm_pkg::OP_LOAD_A, 5'($urandom_range(0, alimbs - 1)), rand_limb());
          else if (r < 84)
            send_word(msm_pkg::OP_LOAD_B, 5'($urandom_range(0, blimbs - 1)), rand_limb());
          else if (r < 92)
            send_word(OP_UNUSED, 5'($urandom()), $urandom());
          else
            send_word(r[0] ? msm_pkg::OP_LOAD_B : msm_pkg::OP_LOAD_A,
                      5'($urandom_range(0, 31)), rand_limb());
        end
        // an occasional load burst with no multiply after it
        if ($urandom_range(0, 9) != 0) begin
          fill_operands();
          send_word(msm_pkg::OP_MULTIPLY, 5'($urandom()), $urandom());
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= msm_pkg::OP_LOAD_A;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= msm_pkg::REG_A_LENGTH;
    cfg_data_i      <= '0;
    a_len_reg = 5'd1;
    b_len_reg = 5'd1;
    a_written = '0;
    b_written = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_length_extremes();
    test_output_backpressure();
    test_random_traffic();

    quiesce();
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && pending_limbs.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Output side: random stalls, calm stretches, one forced long hold.
  initial begin : sink_ready
    int unsigned stall_left;
    int unsigned r;
    bit          calm;
    bit          hold_taken;
    stall_left = 0;
    calm       = 1'b0;
    hold_taken = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_taken) begin
        stall_left = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) calm = !calm;
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (calm) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= 1'b0;
          stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(10, 50);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_products
    product_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_limbs.size() == 0) begin
        $display("%0t: unexpected product word: expected none, got limb %h index %0d last %0b",
                 $time, m_axis_tdata_o[31:0], m_axis_tdata_o[37:32], m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pending_limbs.pop_front();
        if (m_axis_tdata_o[31:0] !== want.limb) begin
          $display("%0t: product_limb mismatch: expected %h, got %h",
                   $time, want.limb, m_axis_tdata_o[31:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[37:32] !== want.index) begin
          $display("%0t: product_index mismatch: expected %0d, got %0d",
                   $time, want.index, m_axis_tdata_o[37:32]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.is_last) begin
          $display("%0t: last_limb mismatch: expected %0b, got %0b",
                   $time, want.is_last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side and no register write.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
